// File: rtl/quadratic_root_solver_assert.svh
// Assertion macros used by the quadratic root solver top level.
`ifndef QUADRATIC_ROOT_SOLVER_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define QRS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication with a delayed consequent, the delay given by n.
`define QRS_ASSERT_DLY(lbl, ante, n, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error(msg);

`endif

// File: rtl/qrs_pkg.sv
// Types, widths and helpers shared by the quadratic root solver modules.
package qrs_pkg;

    localparam int COEF_W = 32;
    localparam int PROD_W = 64;
    localparam int DISC_W = 66;
    localparam int ROOT_W = 33;
    localparam int REM_W  = 37;
    localparam int NUM_W  = 35;
    localparam int MAG_W  = 34;
    localparam int DEN_W  = 33;

    localparam logic [COEF_W-1:0] Q_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W-1:0] Q_MIN = {1'b1, {(COEF_W-1){1'b0}}};

    typedef struct packed {
        logic              none;
        logic [COEF_W-1:0] a;
        logic [COEF_W-1:0] b;
        logic [DISC_W-1:0] disc;
    } qrs_item_t;

    typedef struct packed {
        logic              none;
        logic [COEF_W-1:0] a;
        logic [COEF_W-1:0] b;
    } qrs_side_t;

    typedef struct packed {
        logic       push;
        logic [1:0] inflight;
    } qrs_front_stat_t;

    function automatic logic [COEF_W-1:0] mag32(input logic [COEF_W-1:0] v);
        logic [COEF_W-1:0] n;
        n = ~v + 1'b1;
        return v[COEF_W-1] ? n : v;
    endfunction

endpackage

// File: rtl/qrs_front.sv
// Front end: takes coefficients, forms the discriminant and classifies the item.
module qrs_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic signed [qrs_pkg::COEF_W-1:0] coef_a,
    input  logic signed [qrs_pkg::COEF_W-1:0] coef_b,
    input  logic signed [qrs_pkg::COEF_W-1:0] coef_c,
    output qrs_pkg::qrs_item_t              item,
    output qrs_pkg::qrs_front_stat_t        stat
);
    import qrs_pkg::*;

    logic              v1_reg;
    logic [COEF_W-1:0] a1_reg, b1_reg, c1_reg;
    logic              v2_reg;
    logic [COEF_W-1:0] a2_reg, b2_reg;
    logic              acpos2_reg;
    logic [PROD_W-1:0] bb2_reg, ac2_reg;

    logic              acpos1;
    logic [DISC_W-1:0] fac, bbx;
    logic              none;
    logic [DISC_W-1:0] disc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
        end
    end

    assign acpos1 = (a1_reg != '0) && (c1_reg != '0) && (a1_reg[COEF_W-1] == c1_reg[COEF_W-1]);

    always_ff @(posedge clk)
    begin
        a1_reg     <= coef_a;
        b1_reg     <= coef_b;
        c1_reg     <= coef_c;
        a2_reg     <= a1_reg;
        b2_reg     <= b1_reg;
        acpos2_reg <= acpos1;
        bb2_reg    <= mag32(b1_reg) * mag32(b1_reg);
        ac2_reg    <= mag32(a1_reg) * mag32(c1_reg);
    end

    // 4ac is positive only when a and c share a sign; then it may exceed b*b.
    always_comb
    begin
        fac  = {ac2_reg, 2'b00};
        bbx  = {2'b00, bb2_reg};
        none = 1'b0;
        disc = '0;
        if (acpos2_reg)
        begin
            if (fac > bbx)
                none = 1'b1;
            else
                disc = bbx - fac;
        end
        else
        begin
            disc = bbx + fac;
        end
        if (a2_reg == '0)
            none = 1'b1;
    end

    assign item.none     = none;
    assign item.a        = a2_reg;
    assign item.b        = b2_reg;
    assign item.disc     = none ? '0 : disc;
    assign stat.push     = v2_reg;
    assign stat.inflight = {1'b0, v1_reg} + {1'b0, v2_reg};

endmodule

// File: rtl/qrs_queue.sv
// Small register queue between the front end and the back end.
module qrs_queue #(
    parameter int DEPTH = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  qrs_pkg::qrs_item_t          push_data,
    output logic                        pop_valid,
    output qrs_pkg::qrs_item_t          pop_data,
    output logic [$clog2(DEPTH+1)-1:0]  count
);
    import qrs_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    qrs_item_t         mem_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              pop;

    // The back end never stalls, so a waiting item leaves every cycle.
    assign pop       = (count_reg != '0);
    assign pop_valid = pop;
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign count     = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (!push && pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// File: rtl/qrs_sqrt_pipe.sv
// Pipelined floor square root of the discriminant, one result bit per stage.
module qrs_sqrt_pipe (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [qrs_pkg::DISC_W-1:0]    in_disc,
    input  qrs_pkg::qrs_side_t            in_side,
    output logic                          out_valid,
    output logic [qrs_pkg::ROOT_W-1:0]    out_root,
    output qrs_pkg::qrs_side_t            out_side
);
    import qrs_pkg::*;

    logic              v_reg    [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [DISC_W-1:0] disc_reg [ROOT_W];
    qrs_side_t         side_reg [ROOT_W];

    for (genvar s = 0; s < ROOT_W; s++)
    begin : g_stage
        logic              v_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [DISC_W-1:0] disc_in;
        qrs_side_t         side_in;
        logic [1:0]        pair;
        logic [REM_W-1:0]  rem_sh, trial, rem_next;
        logic [ROOT_W-1:0] root_next;
        logic              ge;

        if (s == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign disc_in = in_disc;
            assign side_in = in_side;
        end
        else
        begin : g_next
            assign v_in    = v_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign disc_in = disc_reg[s-1];
            assign side_in = side_reg[s-1];
        end

        assign pair      = disc_in[DISC_W-1-2*s -: 2];
        assign rem_sh    = {rem_in[REM_W-3:0], pair};
        assign trial     = {{(REM_W-ROOT_W-2){1'b0}}, root_in, 2'b01};
        assign ge        = (rem_sh >= trial);
        assign rem_next  = ge ? (rem_sh - trial) : rem_sh;
        assign root_next = {root_in[ROOT_W-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s] <= 1'b0;
            else
                v_reg[s] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s]  <= rem_next;
            root_reg[s] <= root_next;
            disc_reg[s] <= disc_in;
            side_reg[s] <= side_in;
        end
    end

    assign out_valid = v_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

endmodule

// File: rtl/qrs_div_pipe.sv
// Two-lane pipelined restoring divider with a shared divisor, one quotient bit per stage.
module qrs_div_pipe #(
    parameter int QW = 50
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_none,
    input  logic [qrs_pkg::DEN_W-1:0]   in_den,
    input  logic [QW-1:0]               in_dvd_m,
    input  logic [QW-1:0]               in_dvd_p,
    input  logic                        in_neg_m,
    input  logic                        in_neg_p,
    output logic                        out_valid,
    output logic                        out_none,
    output logic [QW-1:0]               out_q_m,
    output logic [QW-1:0]               out_q_p,
    output logic                        out_neg_m,
    output logic                        out_neg_p
);
    import qrs_pkg::*;

    logic             v_reg    [QW];
    logic             none_reg [QW];
    logic [DEN_W-1:0] den_reg  [QW];
    logic             neg_reg  [QW][2];
    logic [QW-1:0]    dvd_reg  [QW][2];
    logic [DEN_W-1:0] rem_reg  [QW][2];
    logic [QW-1:0]    q_reg    [QW][2];

    for (genvar s = 0; s < QW; s++)
    begin : g_stage
        logic             v_in, none_in;
        logic [DEN_W-1:0] den_in;

        if (s == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign none_in = in_none;
            assign den_in  = in_den;
        end
        else
        begin : g_next
            assign v_in    = v_reg[s-1];
            assign none_in = none_reg[s-1];
            assign den_in  = den_reg[s-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s] <= 1'b0;
            else
                v_reg[s] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            none_reg[s] <= none_in;
            den_reg[s]  <= den_in;
        end

        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            logic             neg_in;
            logic [QW-1:0]    dvd_in, q_in, q_next;
            logic [DEN_W-1:0] rem_in;
            logic [DEN_W:0]   rem_sh, rem_sub;
            logic             ge;

            if (s == 0)
            begin : g_first
                assign neg_in = (l == 0) ? in_neg_m : in_neg_p;
                assign dvd_in = (l == 0) ? in_dvd_m : in_dvd_p;
                assign rem_in = '0;
                assign q_in   = '0;
            end
            else
            begin : g_next
                assign neg_in = neg_reg[s-1][l];
                assign dvd_in = dvd_reg[s-1][l];
                assign rem_in = rem_reg[s-1][l];
                assign q_in   = q_reg[s-1][l];
            end

            assign rem_sh  = {rem_in, dvd_in[QW-1-s]};
            assign ge      = (rem_sh >= {1'b0, den_in});
            assign rem_sub = rem_sh - {1'b0, den_in};
            if (QW > 1)
            begin : g_qw
                assign q_next = {q_in[QW-2:0], ge};
            end
            else
            begin : g_q1
                assign q_next = ge;
            end

            always_ff @(posedge clk)
            begin
                neg_reg[s][l] <= neg_in;
                dvd_reg[s][l] <= dvd_in;
                rem_reg[s][l] <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                q_reg[s][l]   <= q_next;
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign out_none  = none_reg[QW-1];
    assign out_q_m   = q_reg[QW-1][0];
    assign out_q_p   = q_reg[QW-1][1];
    assign out_neg_m = neg_reg[QW-1][0];
    assign out_neg_p = neg_reg[QW-1][1];

endmodule

// File: rtl/quadratic_root_solver.sv
// Top level of the quadratic root solver: front end, queue, root and divide back end.
//
// Usage: drive coef_a, coef_b and coef_c (signed fixed point with FRAC_BITS fraction
// bits) and raise start. A transfer happens on each rising edge where start is high
// and busy is low; a new item may follow in the very next cycle, so the block
// sustains one solve per clock while busy stays low.
// Each item produces exactly one result. done is high for one cycle while root_minus,
// root_plus, no_solution and saturated hold that result, and the result transfers at
// the edge that ends that cycle. The receiver cannot stall, so results leave in order.
// Each item passes the front-end registers, the queue, the 33-stage square root
// pipeline, the numerator register, the 34 + FRAC_BITS-stage divider and the output
// register, one result bit per stage. At the default FRAC_BITS the roots are Q16.16.
// The front end squares b and multiplies a by c, forms the discriminant and flags
// the no-solution case, then pushes the item into a short queue. The back end pops
// it, takes the floor square root, forms both numerators and divides by 2a in two
// lanes, then saturates to 32 bits. busy rises only if the queue could overflow,
// which never happens in normal use since the back end drains it every cycle.
// Reset (rst_n low, asynchronous) empties every stage and the queue; no result
// appears for an item that was in flight.
`include "quadratic_root_solver_assert.svh"

module quadratic_root_solver #(
    parameter int FRAC_BITS   = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [qrs_pkg::COEF_W-1:0] coef_a,
    input  logic signed [qrs_pkg::COEF_W-1:0] coef_b,
    input  logic signed [qrs_pkg::COEF_W-1:0] coef_c,
    output logic                              done,
    output logic signed [qrs_pkg::COEF_W-1:0] root_minus,
    output logic signed [qrs_pkg::COEF_W-1:0] root_plus,
    output logic                              no_solution,
    output logic                              saturated
);
    import qrs_pkg::*;

    localparam int QW      = MAG_W + FRAC_BITS;
    localparam int CW      = $clog2(QUEUE_DEPTH + 1);
    localparam int RES_LAT = 5 + ROOT_W + QW;

    // Front end and queue.
    logic            in_acc;
    qrs_item_t       f_item;
    qrs_front_stat_t f_stat;
    logic            q_valid;
    qrs_item_t       q_item;
    logic [CW-1:0]   q_count;
    logic [CW+1:0]   room_sum;

    // Items still inside the front end, up to two, are counted against the queue space.
    assign room_sum = (CW+2)'(q_count) + (CW+2)'(f_stat.inflight);
    assign busy     = (room_sum >= (CW+2)'(QUEUE_DEPTH));
    assign in_acc   = start && !busy;

    qrs_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (in_acc),
        .coef_a (coef_a),
        .coef_b (coef_b),
        .coef_c (coef_c),
        .item   (f_item),
        .stat   (f_stat)
    );

    qrs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_stat.push),
        .push_data (f_item),
        .pop_valid (q_valid),
        .pop_data  (q_item),
        .count     (q_count)
    );

    // Square root.
    qrs_side_t         q_side;
    logic              s_valid;
    logic [ROOT_W-1:0] s_root;
    qrs_side_t         s_side;

    assign q_side.none = q_item.none;
    assign q_side.a    = q_item.a;
    assign q_side.b    = q_item.b;

    qrs_sqrt_pipe u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_disc   (q_item.disc),
        .in_side   (q_side),
        .out_valid (s_valid),
        .out_root  (s_root),
        .out_side  (s_side)
    );

    // Numerator preparation: -b minus and plus the root, split into sign and magnitude.
    logic [NUM_W-1:0]  nb, rx, num_m, num_p, neg_num_m, neg_num_p;
    logic [MAG_W-1:0]  mag_m, mag_p;
    logic              pv_reg, pnone_reg, pneg_m_reg, pneg_p_reg;
    logic [DEN_W-1:0]  pden_reg;
    logic [QW-1:0]     pdvd_m_reg, pdvd_p_reg;

    assign nb        = NUM_W'(0) - {{(NUM_W-COEF_W){s_side.b[COEF_W-1]}}, s_side.b};
    assign rx        = {{(NUM_W-ROOT_W){1'b0}}, s_root};
    assign num_m     = nb - rx;
    assign num_p     = nb + rx;
    assign neg_num_m = NUM_W'(0) - num_m;
    assign neg_num_p = NUM_W'(0) - num_p;
    assign mag_m     = num_m[NUM_W-1] ? neg_num_m[MAG_W-1:0] : num_m[MAG_W-1:0];
    assign mag_p     = num_p[NUM_W-1] ? neg_num_p[MAG_W-1:0] : num_p[MAG_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pv_reg <= 1'b0;
        else
            pv_reg <= s_valid;
    end

    always_ff @(posedge clk)
    begin
        pnone_reg  <= s_side.none;
        pden_reg   <= {mag32(s_side.a), 1'b0};
        pdvd_m_reg <= {mag_m, {FRAC_BITS{1'b0}}};
        pdvd_p_reg <= {mag_p, {FRAC_BITS{1'b0}}};
        pneg_m_reg <= num_m[NUM_W-1] ^ s_side.a[COEF_W-1];
        pneg_p_reg <= num_p[NUM_W-1] ^ s_side.a[COEF_W-1];
    end

    // Division by 2a.
    logic          d_valid, d_none, d_neg_m, d_neg_p;
    logic [QW-1:0] d_q_m, d_q_p;

    qrs_div_pipe #(
        .QW (QW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pv_reg),
        .in_none   (pnone_reg),
        .in_den    (pden_reg),
        .in_dvd_m  (pdvd_m_reg),
        .in_dvd_p  (pdvd_p_reg),
        .in_neg_m  (pneg_m_reg),
        .in_neg_p  (pneg_p_reg),
        .out_valid (d_valid),
        .out_none  (d_none),
        .out_q_m   (d_q_m),
        .out_q_p   (d_q_p),
        .out_neg_m (d_neg_m),
        .out_neg_p (d_neg_p)
    );

    // Saturation to the 32-bit signed range and the output register.
    logic              done_reg, done_next;
    logic [COEF_W-1:0] root_minus_reg, root_minus_next;
    logic [COEF_W-1:0] root_plus_reg, root_plus_next;
    logic              no_solution_reg, no_solution_next;
    logic              saturated_reg, saturated_next;
    logic              over_m, over_p;
    logic [COEF_W-1:0] val_m, val_p;

    // A positive quotient clips above 2^31-1; a negative one clips below -2^31.
    function automatic logic sat_over(input logic [QW-1:0] q, input logic neg);
        logic hi_any;
        hi_any = |q[QW-1:COEF_W];
        if (neg)
            return hi_any || (q[COEF_W-1] && (|q[COEF_W-2:0]));
        return hi_any || q[COEF_W-1];
    endfunction

    function automatic logic [COEF_W-1:0] sat_val(input logic [QW-1:0] q, input logic neg,
                                                  input logic over);
        logic [COEF_W-1:0] neg_q;
        neg_q = COEF_W'(0) - q[COEF_W-1:0];
        if (neg)
            return over ? Q_MIN : neg_q;
        return over ? Q_MAX : q[COEF_W-1:0];
    endfunction

    assign over_m = sat_over(d_q_m, d_neg_m);
    assign over_p = sat_over(d_q_p, d_neg_p);
    assign val_m  = sat_val(d_q_m, d_neg_m, over_m);
    assign val_p  = sat_val(d_q_p, d_neg_p, over_p);

    always_comb
    begin
        done_next        = d_valid;
        no_solution_next = d_none;
        if (d_none)
        begin
            root_minus_next = '0;
            root_plus_next  = '0;
            saturated_next  = 1'b0;
        end
        else
        begin
            root_minus_next = val_m;
            root_plus_next  = val_p;
            saturated_next  = over_m || over_p;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= done_next;
    end

    always_ff @(posedge clk)
    begin
        root_minus_reg  <= root_minus_next;
        root_plus_reg   <= root_plus_next;
        no_solution_reg <= no_solution_next;
        saturated_reg   <= saturated_next;
    end

    assign done        = done_reg;
    assign root_minus  = root_minus_reg;
    assign root_plus   = root_plus_reg;
    assign no_solution = no_solution_reg;
    assign saturated   = saturated_reg;

    // Checks.
    `QRS_ASSERT_IMP(a_no_sol_zero, done && no_solution,
        (root_minus == '0) && (root_plus == '0) && !saturated,
        "no-solution result carries nonzero roots or saturation")
    `QRS_ASSERT_DLY(a_fixed_latency, in_acc, RES_LAT, done,
        "accepted item did not produce a result at the fixed latency")
    `QRS_ASSERT_IMP(a_done_source, done, $past(in_acc, RES_LAT),
        "result appeared without a matching accepted item")
    `QRS_ASSERT_IMP(a_queue_room, f_stat.push, q_count < CW'(QUEUE_DEPTH),
        "front end pushed into a full queue")

endmodule
